FILE: rtl/cdq_pkg.sv
// Package for the circular double-ended queue: payload structs, opcodes,
// status codes and the command/status structs between controller and datapath.
// No dependencies.
package cdq_pkg;

  localparam int DEPTH_DEFAULT = 64;
  localparam int DATA_W        = 32;

  localparam logic [2:0] OP_SHOW      = 3'd0;
  localparam logic [2:0] OP_PUSH_FRNT = 3'd1;
  localparam logic [2:0] OP_PUSH_BACK = 3'd2;
  localparam logic [2:0] OP_POP_FRNT  = 3'd3;
  localparam logic [2:0] OP_POP_BACK  = 3'd4;

  localparam logic [1:0] ST_OK    = 2'd0;
  localparam logic [1:0] ST_EMPTY = 2'd1;
  localparam logic [1:0] ST_FULL  = 2'd2;

  typedef struct packed {
    logic [2:0]               opcode;
    logic signed [DATA_W-1:0] value_in;
  } in_t;

  typedef struct packed {
    logic signed [DATA_W-1:0] value_out;
    logic [1:0]               status;
    logic                     last;
  } out_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic       push_front;
    logic       push_back;
    logic       pop_front;
    logic       pop_back;
    logic       show_first;
    logic       show_next;
    logic       emit_rdata;
    logic       emit_last;
    logic       emit_status;
    logic [1:0] status;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic empty;
    logic full;
    logic show_done;
  } dp_stat_t;

endpackage

FILE: rtl/cdq_ram.sv
// Generic single-write, single-read RAM with a registered read port.
// No dependencies.
module cdq_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 64,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rd_data_r;

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
    rd_data_r <= mem_r[rd_addr];
  end

  assign rd_data = rd_data_r;

endmodule

FILE: rtl/cdq_ctrl.sv
// Controller state machine for the circular double-ended queue.
// Depends on cdq_pkg for opcodes, status codes and the cmd_t/dp_stat_t structs.
module cdq_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              start,
  input  logic [2:0]        opcode,
  input  cdq_pkg::dp_stat_t dp_stat,
  output cdq_pkg::cmd_t     cmd,
  output logic              busy
);
  import cdq_pkg::*;

  localparam logic [1:0] S_IDLE = 2'd0;
  localparam logic [1:0] S_POP  = 2'd1;
  localparam logic [1:0] S_SHOW = 2'd2;

  logic [1:0] state_r;
  logic [1:0] state_nxt;

  always_comb begin
    cmd       = '0;
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (start) begin
          unique case (opcode) inside
            OP_SHOW: begin
              if (dp_stat.empty) begin
                cmd.emit_status = 1'b1;
                cmd.status      = ST_EMPTY;
              end else begin
                cmd.show_first = 1'b1;
                state_nxt      = S_SHOW;
              end
            end
            OP_PUSH_FRNT, OP_PUSH_BACK: begin
              cmd.emit_status = 1'b1;
              if (dp_stat.full) begin
                cmd.status = ST_FULL;
              end else begin
                cmd.status     = ST_OK;
                cmd.push_front = (opcode == OP_PUSH_FRNT);
                cmd.push_back  = (opcode == OP_PUSH_BACK);
              end
            end
            OP_POP_FRNT, OP_POP_BACK: begin
              if (dp_stat.empty) begin
                cmd.emit_status = 1'b1;
                cmd.status      = ST_EMPTY;
              end else begin
                cmd.pop_front = (opcode == OP_POP_FRNT);
                cmd.pop_back  = (opcode == OP_POP_BACK);
                state_nxt     = S_POP;
              end
            end
            default: begin
              cmd.emit_status = 1'b1;
              cmd.status      = ST_OK;
            end
          endcase
        end
      end
      S_POP: begin
        cmd.emit_rdata = 1'b1;
        cmd.emit_last  = 1'b1;
        state_nxt      = S_IDLE;
      end
      S_SHOW: begin
        cmd.emit_rdata = 1'b1;
        cmd.emit_last  = dp_stat.show_done;
        if (dp_stat.show_done) begin
          state_nxt = S_IDLE;
        end else begin
          cmd.show_next = 1'b1;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  assign busy = (state_r != S_IDLE);

  // A pop always returns to idle straight after its read-back state.
  a_pop_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_POP) |=> (state_r == S_IDLE))
    else $error("pop wait lasted more than one cycle");

  // The walk ends exactly on the cycle that carries the last mark.
  a_show_ends_on_last: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_SHOW && cmd.emit_last) |=> (state_r == S_IDLE))
    else $error("show walk did not end on its last entry");

  // A new item is never taken while a pop or a walk is in flight.
  a_no_new_cmd_busy: assert property (@(posedge clk) disable iff (!rst_n)
    busy |-> !(cmd.push_front || cmd.push_back || cmd.pop_front || cmd.pop_back
               || cmd.show_first))
    else $error("queue command issued while busy");

endmodule

FILE: rtl/cdq_dpath.sv
// Datapath for the circular double-ended queue: front index, entry count,
// walk index, entry RAM and result register.
// Depends on cdq_pkg and cdq_ram.
module cdq_dpath #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic              clk,
  input  logic              rst_n,
  input  cdq_pkg::cmd_t     cmd,
  input  logic signed [cdq_pkg::DATA_W-1:0] value_in,
  output cdq_pkg::dp_stat_t dp_stat,
  output logic              out_valid,
  output cdq_pkg::out_t     out_item
);
  import cdq_pkg::*;

  localparam int IW = $clog2(DEPTH);
  localparam int CW = $clog2(DEPTH + 1);

  logic [IW-1:0]     front_r, front_nxt;
  logic [CW-1:0]     count_r, count_nxt;
  logic [IW-1:0]     idx_r, idx_nxt;
  logic              out_valid_r, out_valid_nxt;
  out_t              out_r, out_nxt;
  logic              wr_en;
  logic [IW-1:0]     wr_addr;
  logic [IW-1:0]     rd_addr;
  logic [DATA_W-1:0] rd_data;
  logic [IW-1:0]     front_dec;
  logic [IW-1:0]     front_inc;
  logic [CW-1:0]     idx_plus1;

  // Ring slot at a given offset from a base; the sum stays below twice the depth.
  function automatic logic [IW-1:0] slot_of(input logic [IW-1:0] base,
                                            input logic [CW-1:0] off);
    logic [CW:0] sum;
    sum = (CW+1)'(base) + (CW+1)'(off);
    if (sum >= (CW+1)'(DEPTH)) begin
      sum = sum - (CW+1)'(DEPTH);
    end
    return sum[IW-1:0];
  endfunction

  assign front_dec = (front_r == '0) ? IW'(DEPTH - 1) : front_r - 1'b1;
  assign front_inc = (front_r == IW'(DEPTH - 1)) ? '0 : front_r + 1'b1;
  assign idx_plus1 = CW'(idx_r) + 1'b1;

  assign dp_stat.empty     = (count_r == '0);
  assign dp_stat.full      = (count_r == CW'(DEPTH));
  assign dp_stat.show_done = (idx_plus1 == count_r);

  always_comb begin
    front_nxt = front_r;
    count_nxt = count_r;
    idx_nxt   = idx_r;
    wr_en     = 1'b0;
    wr_addr   = slot_of(front_r, count_r);
    rd_addr   = front_r;
    if (cmd.push_front) begin
      wr_en     = 1'b1;
      wr_addr   = front_dec;
      front_nxt = front_dec;
      count_nxt = count_r + 1'b1;
    end
    if (cmd.push_back) begin
      wr_en     = 1'b1;
      count_nxt = count_r + 1'b1;
    end
    if (cmd.pop_front) begin
      front_nxt = front_inc;
      count_nxt = count_r - 1'b1;
    end
    if (cmd.pop_back) begin
      rd_addr   = slot_of(front_r, count_r - 1'b1);
      count_nxt = count_r - 1'b1;
    end
    if (cmd.show_first) begin
      idx_nxt = '0;
    end
    if (cmd.show_next) begin
      rd_addr = slot_of(front_r, idx_plus1);
      idx_nxt = idx_plus1[IW-1:0];
    end
  end

  always_comb begin
    out_valid_nxt = cmd.emit_rdata || cmd.emit_status;
    out_nxt       = out_r;
    if (cmd.emit_rdata) begin
      out_nxt.value_out = rd_data;
      out_nxt.status    = ST_OK;
      out_nxt.last      = cmd.emit_last;
    end else if (cmd.emit_status) begin
      out_nxt.value_out = '0;
      out_nxt.status    = cmd.status;
      out_nxt.last      = 1'b1;
    end
  end

  cdq_ram #(
    .WIDTH (DATA_W),
    .DEPTH (DEPTH),
    .AW    (IW)
  ) u_ram (
    .clk     (clk),
    .wr_en   (wr_en),
    .wr_addr (wr_addr),
    .wr_data (value_in),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      front_r     <= '0;
      count_r     <= '0;
      idx_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      front_r     <= front_nxt;
      count_r     <= count_nxt;
      idx_r       <= idx_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    out_r <= out_nxt;
  end

  assign out_valid = out_valid_r;
  assign out_item  = out_r;

  a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
    count_r <= CW'(DEPTH))
    else $error("entry count exceeds depth");

  a_one_queue_op: assert property (@(posedge clk) disable iff (!rst_n)
    $onehot0({cmd.push_front, cmd.push_back, cmd.pop_front, cmd.pop_back,
              cmd.show_first, cmd.show_next}))
    else $error("more than one queue operation in a cycle");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (cmd.push_front || cmd.push_back) |=> (count_r == $past(count_r) + 1'b1))
    else $error("push did not add an entry");

  a_error_is_last: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_r.status != ST_OK) |-> out_r.last)
    else $error("error report without last mark");

endmodule

FILE: rtl/circular_deque_push_pop.sv
// Top level of the circular double-ended queue.
// Depends on cdq_pkg, cdq_ctrl, cdq_dpath (and through it cdq_ram).
//
// A bounded double-ended queue of DEPTH signed 32-bit entries kept in a ring
// buffer with a front index and an entry count. An item is transferred in at
// a rising edge where start is high and busy is low; in_item carries the
// opcode (show all, push front, push back, pop front, pop back) and the value
// to push. Every result appears on out_item for exactly one cycle with
// out_valid high, and the receiver cannot hold it off, so it must take each
// result as it comes. A push, a report of full or empty, and an unused opcode
// each give one result in the cycle after the transfer, and busy stays low,
// so such items can follow every cycle. A pop reads the entry RAM, whose read
// port is registered, so busy is high during the controller's read-back state
// and the result passes through the RAM read register and then the result
// register. A show walks the RAM one entry per cycle: with N entries, busy
// stays high for the whole walk and the N results leave back to back, the last
// one marked. The entry RAM needs no clearing pass after reset; only live slots are read.
module circular_deque_push_pop #(
  parameter int DEPTH = cdq_pkg::DEPTH_DEFAULT
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  output logic          busy,
  input  cdq_pkg::in_t  in_item,
  output logic          out_valid,
  output cdq_pkg::out_t out_item
);
  import cdq_pkg::*;

  cmd_t     cmd;
  dp_stat_t dp_stat;
  logic     ctrl_busy;

  // The controller sees the opcode directly; it only acts on it in idle,
  // which is exactly when a transfer can happen.
  cdq_ctrl u_ctrl (
    .clk     (clk),
    .rst_n   (rst_n),
    .start   (start),
    .opcode  (in_item.opcode),
    .dp_stat (dp_stat),
    .cmd     (cmd),
    .busy    (ctrl_busy)
  );

  // The datapath holds the ring pointers, the entry RAM and the result
  // register that drives the output strobe.
  cdq_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk       (clk),
    .rst_n     (rst_n),
    .cmd       (cmd),
    .value_in  (in_item.value_in),
    .dp_stat   (dp_stat),
    .out_valid (out_valid),
    .out_item  (out_item)
  );

  assign busy = ctrl_busy;

endmodule

FILE: dv/circular_deque_push_pop_test.sv
// Self-checking testbench for circular_deque_push_pop: directed and random deque operations,
// with a behavioral deque model that predicts every result, checked field by field.
// Depends on cdq_pkg and the circular_deque_push_pop RTL.
module circular_deque_push_pop_test;
  import cdq_pkg::*;

  localparam int DEPTH = DEPTH_DEFAULT;

  // Clock, reset and the block's inputs all start at known values.
  logic clk = 1'b0;
  logic rst_n = 1'b0;
  logic start = 1'b0;
  in_t in_item = '0;
  logic busy;
  logic out_valid;
  out_t out_item;

  // Behavioral copy of the deque: ring storage, front slot and live entry count.
  logic signed [DATA_W-1:0] deque_store [DEPTH];
  int unsigned deque_front = 0;
  int unsigned deque_count = 0;

  // Results the block still owes, oldest first.
  out_t pending_results [$];
  int unsigned failures = 0;

  // When set, the sender inserts random gaps after each transfer.
  bit gaps_on = 1'b1;

  circular_deque_push_pop #(
    .DEPTH(DEPTH)
  ) i_dut (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (start),
    .busy     (busy),
    .in_item  (in_item),
    .out_valid(out_valid),
    .out_item (out_item)
  );

  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Works out the results of one accepted item and updates the deque model.
  // A show lists every live entry front to back; everything else gives one result.
  task automatic predict_deque(input in_t item);
    out_t r;
    int unsigned k;
    r = '0;
    r.status = ST_OK;
    r.last = 1'b1;
    case (item.opcode)
      OP_SHOW: begin
        if (deque_count == 0) begin
          r.status = ST_EMPTY;
          pending_results.push_back(r);
        end else begin
          for (k = 0; k < deque_count; k++) begin
            r.value_out = deque_store[(deque_front + k) % DEPTH];
            r.last = (k == deque_count - 1);
            pending_results.push_back(r);
          end
        end
      end
      OP_PUSH_FRNT, OP_PUSH_BACK: begin
        // A full deque refuses the push and stays as it is.
        if (deque_count == DEPTH) begin
          r.status = ST_FULL;
        end else begin
          if (item.opcode == OP_PUSH_FRNT) begin
            deque_front = (deque_front + DEPTH - 1) % DEPTH;
            deque_store[deque_front] = item.value_in;
          end else begin
            deque_store[(deque_front + deque_count) % DEPTH] = item.value_in;
          end
          deque_count++;
        end
        pending_results.push_back(r);
      end
      OP_POP_FRNT, OP_POP_BACK: begin
        // Popping the only entry simply brings the count back to zero.
        if (deque_count == 0) begin
          r.status = ST_EMPTY;
        end else if (item.opcode == OP_POP_FRNT) begin
          r.value_out = deque_store[deque_front];
          deque_front = (deque_front + 1) % DEPTH;
          deque_count--;
        end else begin
          r.value_out = deque_store[(deque_front + deque_count - 1) % DEPTH];
          deque_count--;
        end
        pending_results.push_back(r);
      end
      default: begin
        // Unused opcodes are acknowledged and otherwise ignored.
        pending_results.push_back(r);
      end
    endcase
  endtask

  // Result checker. Outputs are sampled at the rising edge, before the block's
  // registers update, so each strobe is seen in the cycle it is presented.
  always @(posedge clk) begin
    out_t want;
    if (rst_n && out_valid === 1'b1) begin
      if (pending_results.size() == 0) begin
        failures++;
        $display("%0t: unexpected result value_out=%0d status=%0d last=%0d", $time,
                 out_item.value_out, out_item.status, out_item.last);
      end else begin
        want = pending_results.pop_front();
        if (out_item.value_out !== want.value_out) begin
          failures++;
          $display("%0t: value_out expected %0d, actual %0d", $time,
                   want.value_out, out_item.value_out);
        end
        if (out_item.status !== want.status) begin
          failures++;
          $display("%0t: status expected %0d, actual %0d", $time,
                   want.status, out_item.status);
        end
        if (out_item.last !== want.last) begin
          failures++;
          $display("%0t: last expected %0d, actual %0d", $time, want.last, out_item.last);
        end
      end
    end
  end

  // Lowers start at the first falling edge and keeps it low for an idle gap of length n.
  task automatic idle_cycles(input int unsigned n);
    @(negedge clk);
    start <= 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  // Mostly no gap or a short one, now and then a long one.
  function automatic int unsigned pick_gap();
    int unsigned r;
    r = $urandom_range(0, 99);
    if (r < 45) return 0;
    if (r < 85) return $urandom_range(1, 3);
    if (r < 97) return $urandom_range(4, 10);
    return $urandom_range(20, 40);
  endfunction

  // Presents one item and holds it until the block takes it. The transfer
  // happens at the rising edge where start is high and busy is low. Start is
  // left high when no gap follows, so back-to-back items see no bubble; the
  // next falling edge then carries exactly one assignment to start.
  task automatic send_item(input logic [2:0] op, input logic signed [DATA_W-1:0] val);
    in_t item;
    int unsigned gap;
    item.opcode = op;
    item.value_in = val;
    @(negedge clk);
    start <= 1'b1;
    in_item <= item;
    do @(posedge clk); while (busy !== 1'b0);
    predict_deque(item);
    gap = gaps_on ? pick_gap() : 0;
    if (gap != 0) idle_cycles(gap);
  endtask

  // Stops sending and waits for every owed result, then idles on so that any
  // stray extra strobe would still be caught.
  task automatic drain_deque();
    idle_cycles(1);
    while (pending_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  // Random data that favors the sign boundaries now and then.
  function automatic logic signed [DATA_W-1:0] random_value();
    case ($urandom_range(0, 9))
      0: return 32'sh7fff_ffff;
      1: return 32'sh8000_0000;
      2: return '0;
      3: return '1;
      default: return $urandom;
    endcase
  endfunction

  // Show and pops on an empty deque report empty; unused opcodes get a plain ack.
  task automatic test_empty_deque();
    send_item(OP_SHOW, random_value());
    send_item(OP_POP_FRNT, random_value());
    send_item(OP_POP_BACK, random_value());
    send_item(3'd5, random_value());
    send_item(3'd6, random_value());
    send_item(3'd7, random_value());
    drain_deque();
  endtask

  // Extreme values at both ends, a show, pops from both ends, and popping the
  // only entry from each end. The first front push wraps the front index.
  task automatic test_both_ends();
    send_item(OP_PUSH_FRNT, 32'sh8000_0000);
    send_item(OP_PUSH_BACK, 32'sh7fff_ffff);
    send_item(OP_PUSH_FRNT, '1);
    send_item(OP_PUSH_BACK, '0);
    send_item(OP_PUSH_BACK, 32'sh5555_aaaa);
    send_item(3'd7, 32'sh1234_5678);
    send_item(OP_SHOW, '0);
    send_item(OP_POP_FRNT, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRNT, '0);
    send_item(OP_POP_BACK, '0);
    send_item(OP_POP_FRNT, '0);
    send_item(OP_PUSH_FRNT, 32'sh0f0f_0f0f);
    send_item(OP_POP_FRNT, '0);
    send_item(OP_PUSH_BACK, 32'sh7ead_beef);
    send_item(OP_POP_BACK, '0);
    send_item(OP_SHOW, '0);
    drain_deque();
  endtask

  // Random mix that keeps the deque shallow, so shows stay short and pops on an
  // empty deque come up often. Now and then the sender waits for all results.
  task automatic test_random_mix(input int unsigned n_items);
    int unsigned r;
    logic [2:0] op;
    repeat (n_items) begin
      r = $urandom_range(0, 99);
      if (r < 8) op = OP_SHOW;
      else if (r < 32) op = OP_PUSH_FRNT;
      else if (r < 56) op = OP_PUSH_BACK;
      else if (r < 76) op = OP_POP_FRNT;
      else if (r < 96) op = OP_POP_BACK;
      else op = 3'($urandom_range(5, 7));
      send_item(op, random_value());
      if ($urandom_range(0, 99) < 4) drain_deque();
    end
    drain_deque();
  endtask

  // Fills the deque back to back from both ends, tries to push past full at
  // each end, shows all DEPTH entries, then empties it with gaps enabled.
  task automatic test_fill_and_empty();
    gaps_on = 1'b0;
    while (deque_count < DEPTH)
      send_item($urandom_range(0, 1) ? OP_PUSH_FRNT : OP_PUSH_BACK, random_value());
    send_item(OP_PUSH_FRNT, random_value());
    send_item(OP_PUSH_BACK, random_value());
    gaps_on = 1'b1;
    send_item(OP_SHOW, random_value());
    while (deque_count > 0)
      send_item($urandom_range(0, 1) ? OP_POP_FRNT : OP_POP_BACK, random_value());
    send_item(OP_POP_BACK, random_value());
    drain_deque();
  endtask

  // Reset once, run the tests in turn, then give the verdict.
  initial begin
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    test_empty_deque();
    test_both_ends();
    test_random_mix(60);
    test_fill_and_empty();
    test_random_mix(60);
    if (failures == 0) begin
      $display("** circular_deque_push_pop: PASSED **");
    end else begin
      $display("** circular_deque_push_pop: FAILED **");
    end
    $finish;
  end

  // Watchdog: far beyond the slowest correct run of this stimulus.
  initial begin
    #5_000_000;
    $display("** circular_deque_push_pop: FAILED **");
    $finish;
  end

endmodule

FILE: circular_deque_push_pop.f
rtl/cdq_pkg.sv
rtl/cdq_ram.sv
rtl/cdq_ctrl.sv
rtl/cdq_dpath.sv
rtl/circular_deque_push_pop.sv
dv/circular_deque_push_pop_test.sv
